>>> rtl/lav_pkg.sv
// look-at view matrix: shared types, widths and fixed-point helpers
// used by lav_front, lav_norm, lav_back and the top level; no dependencies
package lav_pkg;

	// widths of the datapath
	localparam int CW  = 32;  // coordinate width, signed Q16.16
	localparam int DW  = 33;  // eye minus target
	localparam int NW  = 51;  // signed vector width into the normalizer
	localparam int MW  = 50;  // magnitude width inside the normalizer
	localparam int AW  = 20;  // normalized axis component width
	localparam int ACW = 52;  // product and accumulator width

	localparam logic [CW-1:0] Q_ONE = 32'h0001_0000;

	// one queued item: view direction plus eye and up
	typedef struct packed {
		logic [DW-1:0] dx;
		logic [DW-1:0] dy;
		logic [DW-1:0] dz;
		logic [CW-1:0] eye_x;
		logic [CW-1:0] eye_y;
		logic [CW-1:0] eye_z;
		logic [CW-1:0] up_x;
		logic [CW-1:0] up_y;
		logic [CW-1:0] up_z;
	} item_t;

	// Q20.32 to Q36.16, nearest, ties away from zero
	function automatic logic signed [ACW-1:0] round16(input logic signed [ACW-1:0] v);
		logic [ACW-1:0] mag;
		logic [ACW-1:0] m;
		mag = v[ACW-1] ? (~v + 1'b1) : v;
		m = (mag + ACW'(32768)) >> 16;
		return v[ACW-1] ? $signed(~m + 1'b1) : $signed(m);
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic [CW-1:0] sat32(input logic signed [ACW-1:0] v);
		logic signed [ACW-1:0] hi;
		logic signed [ACW-1:0] lo;
		hi = ACW'(64'sh0000_0000_7fff_ffff);
		lo = -ACW'(64'sh0000_0000_8000_0000);
		if (v > hi) return 32'h7fff_ffff;
		else if (v < lo) return 32'h8000_0000;
		else return v[CW-1:0];
	endfunction

endpackage

>>> rtl/lav_front.sv
// look-at view matrix front end: takes input transfers, forms eye minus
// target and holds items in a two-entry queue for the back end; uses lav_pkg
module lav_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          target_x,
	input  logic [31:0]          target_y,
	input  logic [31:0]          target_z,
	input  logic [31:0]          eye_x,
	input  logic [31:0]          eye_y,
	input  logic [31:0]          eye_z,
	input  logic [31:0]          up_x,
	input  logic [31:0]          up_y,
	input  logic [31:0]          up_z,
	output logic                 q_valid,
	output lav_pkg::item_t       q_item,
	input  logic                 q_pop
);
	import lav_pkg::*;

	item_t       fifo_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        push;
	item_t       item_w;

	// direction vector, sign-extended so the difference never wraps
	always_comb begin
		item_w.dx = DW'($signed(eye_x)) - DW'($signed(target_x));
		item_w.dy = DW'($signed(eye_y)) - DW'($signed(target_y));
		item_w.dz = DW'($signed(eye_z)) - DW'($signed(target_z));
		item_w.eye_x = eye_x;
		item_w.eye_y = eye_y;
		item_w.eye_z = eye_z;
		item_w.up_x = up_x;
		item_w.up_y = up_y;
		item_w.up_z = up_z;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = fifo_q[rd_q];

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			case ({push, q_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= item_w;
	end

endmodule

>>> rtl/lav_norm.sv
// look-at view matrix normalizer: scales a 3-vector to Q16.16 unit length
// with shift steps, a bit-serial square root and bit-serial divides; uses lav_pkg
module lav_norm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [lav_pkg::NW-1:0] v0,
	input  logic signed [lav_pkg::NW-1:0] v1,
	input  logic signed [lav_pkg::NW-1:0] v2,
	output logic                        done,
	output logic                        zero,
	output logic signed [lav_pkg::AW-1:0] r0,
	output logic signed [lav_pkg::AW-1:0] r1,
	output logic signed [lav_pkg::AW-1:0] r2
);
	import lav_pkg::*;

	typedef enum logic [5:0] {
		N_IDLE  = 6'b000001,
		N_SHIFT = 6'b000010,
		N_SQ    = 6'b000100,
		N_SQRT  = 6'b001000,
		N_DLOAD = 6'b010000,
		N_DIV   = 6'b100000
	} nstate_t;

	nstate_t              state_q;
	logic                 done_q;
	logic [MW-1:0]        mag_q [3];
	logic                 neg_q [3];
	logic [MW-1:0]        m_q;
	logic [1:0]           k_q;
	logic [63:0]          rem_q;
	logic [63:0]          root_q;
	logic [63:0]          bit_q;
	logic [31:0]          len_q;
	logic [48:0]          drem_q;
	logic [47:0]          dsor_q;
	logic [16:0]          quo_q;
	logic [4:0]           dcnt_q;
	logic signed [AW-1:0] res_q [3];
	logic                 zero_q;

	logic [MW-1:0]        smag [3];
	logic [MW-1:0]        smax;
	logic                 big_w;
	logic                 small_w;
	logic [61:0]          sq_w;
	logic [63:0]          try_w;
	logic [63:0]          root_nx;
	logic                 take_w;
	logic                 dtake_w;
	logic [16:0]          quo_nx;

	// magnitudes and their maximum at start
	always_comb begin
		smag[0] = v0[NW-1] ? MW'(-v0) : MW'(v0);
		smag[1] = v1[NW-1] ? MW'(-v1) : MW'(v1);
		smag[2] = v2[NW-1] ? MW'(-v2) : MW'(v2);
		smax = smag[0];
		if (smag[1] > smax) smax = smag[1];
		if (smag[2] > smax) smax = smag[2];
	end

	// scaling decision, square, root step and divide step
	assign big_w = |m_q[MW-1:31];
	assign small_w = !big_w && !m_q[30];
	assign sq_w = mag_q[k_q][30:0] * mag_q[k_q][30:0];
	assign try_w = root_q + bit_q;
	assign take_w = (rem_q >= try_w);
	assign root_nx = take_w ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	assign dtake_w = (drem_q >= {1'b0, dsor_q});
	assign quo_nx = {quo_q[15:0], dtake_w};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						if (smax == '0) done_q <= 1'b1;
						else state_q <= N_SHIFT;
					end
				end
				N_SHIFT: if (!big_w && !small_w) state_q <= N_SQ;
				N_SQ: if (k_q == 2'd2) state_q <= N_SQRT;
				N_SQRT: if (bit_q[0]) state_q <= N_DLOAD;
				N_DLOAD: state_q <= N_DIV;
				N_DIV: begin
					if (dcnt_q == 5'd16) begin
						if (k_q == 2'd2) begin
							state_q <= N_IDLE;
							done_q <= 1'b1;
						end else begin
							state_q <= N_DLOAD;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					mag_q[0] <= smag[0];
					mag_q[1] <= smag[1];
					mag_q[2] <= smag[2];
					neg_q[0] <= v0[NW-1];
					neg_q[1] <= v1[NW-1];
					neg_q[2] <= v2[NW-1];
					m_q <= smax;
					k_q <= 2'd0;
					rem_q <= '0;
					zero_q <= (smax == '0);
					if (smax == '0) begin
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= '0;
					end
				end
			end
			N_SHIFT: begin
				// bring the largest magnitude into [2^30, 2^31)
				if (big_w) begin
					m_q <= m_q >> 1;
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end else if (small_w) begin
					m_q <= m_q << 1;
					mag_q[0] <= mag_q[0] << 1;
					mag_q[1] <= mag_q[1] << 1;
					mag_q[2] <= mag_q[2] << 1;
				end
			end
			N_SQ: begin
				// sum of squares, one component a cycle
				rem_q <= rem_q + 64'(sq_w);
				if (k_q == 2'd2) begin
					k_q <= 2'd0;
					root_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			N_SQRT: begin
				// one result bit a cycle
				if (take_w) rem_q <= rem_q - try_w;
				root_q <= root_nx;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) len_q <= root_nx[31:0];
			end
			N_DLOAD: begin
				drem_q <= {2'b00, mag_q[k_q][30:0], 16'h0000} + 49'(len_q >> 1);
				dsor_q <= {len_q, 16'h0000};
				quo_q <= '0;
				dcnt_q <= 5'd0;
			end
			N_DIV: begin
				// restoring divide, one quotient bit a cycle
				if (dtake_w) drem_q <= drem_q - {1'b0, dsor_q};
				dsor_q <= dsor_q >> 1;
				quo_q <= quo_nx;
				dcnt_q <= dcnt_q + 5'd1;
				if (dcnt_q == 5'd16) begin
					res_q[k_q] <= neg_q[k_q] ? -$signed(AW'(quo_nx)) : $signed(AW'(quo_nx));
					k_q <= k_q + 2'd1;
				end
			end
			default: k_q <= 2'd0;
		endcase
	end

	assign done = done_q;
	assign zero = zero_q;
	assign r0 = res_q[0];
	assign r1 = res_q[1];
	assign r2 = res_q[2];

endmodule

>>> rtl/lav_back.sv
// look-at view matrix back end: sequences normalizer runs and a shared
// multiply-accumulate, then hands rows to the output buffer; uses lav_pkg, lav_norm
module lav_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  lav_pkg::item_t       q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           row_number,
	output logic [31:0]          elem0,
	output logic [31:0]          elem1,
	output logic [31:0]          elem2,
	output logic [31:0]          elem3,
	output logic                 last_row,
	output logic                 degenerate
);
	import lav_pkg::*;

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_NZ   = 6'b000010,
		B_C    = 6'b000100,
		B_NX   = 6'b001000,
		B_YT   = 6'b010000,
		B_HAND = 6'b100000
	} bstate_t;

	typedef enum logic [3:0] {
		D_NONE, D_C0, D_C1, D_C2, D_Y0, D_Y1, D_Y2, D_T0, D_T1, D_T2
	} dst_t;

	bstate_t               state_q;
	logic [3:0]            step_q;
	logic                  cstart_q;
	logic [CW-1:0]         eye_q [3];
	logic [CW-1:0]         up_q [3];
	logic signed [AW-1:0]  z_q [3];
	logic signed [AW-1:0]  x_q [3];
	logic signed [AW-1:0]  y_q [3];
	logic signed [ACW-1:0] c_q [3];
	logic [CW-1:0]         t_q [3];
	logic                  degen_q;
	logic signed [ACW-1:0] acc_q;

	logic signed [ACW-1:0] prod_s1;
	logic                  vld_s1;
	logic                  sub_s1;
	logic                  first_s1;
	dst_t                  dst_s1;

	logic                  ob_busy_q;
	logic [1:0]            row_q;
	logic signed [AW-1:0]  ob_x_q [3];
	logic signed [AW-1:0]  ob_y_q [3];
	logic signed [AW-1:0]  ob_z_q [3];
	logic [CW-1:0]         ob_t_q [3];
	logic                  ob_degen_q;

	logic                  nstart;
	logic signed [NW-1:0]  nv0, nv1, nv2;
	logic                  ndone;
	logic                  nzero;
	logic signed [AW-1:0]  nr0, nr1, nr2;

	logic                  issue;
	logic [4:0]            op_w;
	logic signed [CW-1:0]  opa;
	logic signed [AW-1:0]  opb;
	logic                  op_sub;
	logic                  op_first;
	dst_t                  op_dst;
	logic signed [ACW-1:0] acc_nx;
	logic signed [ACW-1:0] rnd_w;
	logic                  hand;
	logic                  out_xfer;

	// normalizer: direction at pop, then the raw x axis
	assign q_pop = (state_q == B_IDLE) && q_valid;
	assign nstart = q_pop || cstart_q;
	assign nv0 = cstart_q ? c_q[0][NW-1:0] : NW'($signed(q_item.dx));
	assign nv1 = cstart_q ? c_q[1][NW-1:0] : NW'($signed(q_item.dy));
	assign nv2 = cstart_q ? c_q[2][NW-1:0] : NW'($signed(q_item.dz));

	lav_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart),
		.v0     (nv0),
		.v1     (nv1),
		.v2     (nv2),
		.done   (ndone),
		.zero   (nzero),
		.r0     (nr0),
		.r1     (nr1),
		.r2     (nr2)
	);

	// operation schedule for the shared multiplier
	assign issue = (state_q == B_C) || (state_q == B_YT);
	assign op_w = (state_q == B_C) ? {1'b0, step_q} : {1'b0, step_q} + 5'd6;

	always_comb begin
		opa = '0;
		opb = '0;
		op_sub = 1'b0;
		op_first = 1'b0;
		op_dst = D_NONE;
		case (op_w)
			5'd0:  begin opa = up_q[1]; opb = z_q[2]; op_first = 1'b1; end
			5'd1:  begin opa = up_q[2]; opb = z_q[1]; op_sub = 1'b1; op_dst = D_C0; end
			5'd2:  begin opa = up_q[2]; opb = z_q[0]; op_first = 1'b1; end
			5'd3:  begin opa = up_q[0]; opb = z_q[2]; op_sub = 1'b1; op_dst = D_C1; end
			5'd4:  begin opa = up_q[0]; opb = z_q[1]; op_first = 1'b1; end
			5'd5:  begin opa = up_q[1]; opb = z_q[0]; op_sub = 1'b1; op_dst = D_C2; end
			5'd6:  begin opa = CW'(z_q[1]); opb = x_q[2]; op_first = 1'b1; end
			5'd7:  begin opa = CW'(z_q[2]); opb = x_q[1]; op_sub = 1'b1; op_dst = D_Y0; end
			5'd8:  begin opa = CW'(z_q[2]); opb = x_q[0]; op_first = 1'b1; end
			5'd9:  begin opa = CW'(z_q[0]); opb = x_q[2]; op_sub = 1'b1; op_dst = D_Y1; end
			5'd10: begin opa = CW'(z_q[0]); opb = x_q[1]; op_first = 1'b1; end
			5'd11: begin opa = CW'(z_q[1]); opb = x_q[0]; op_sub = 1'b1; op_dst = D_Y2; end
			5'd12: begin opa = eye_q[0]; opb = x_q[0]; op_first = 1'b1; end
			5'd13: begin opa = eye_q[1]; opb = x_q[1]; end
			5'd14: begin opa = eye_q[2]; opb = x_q[2]; op_dst = D_T0; end
			5'd15: begin opa = eye_q[0]; opb = y_q[0]; op_first = 1'b1; end
			5'd16: begin opa = eye_q[1]; opb = y_q[1]; end
			5'd17: begin opa = eye_q[2]; opb = y_q[2]; op_dst = D_T1; end
			5'd18: begin opa = eye_q[0]; opb = z_q[0]; op_first = 1'b1; end
			5'd19: begin opa = eye_q[1]; opb = z_q[1]; end
			5'd20: begin opa = eye_q[2]; opb = z_q[2]; op_dst = D_T2; end
			default: op_dst = D_NONE;
		endcase
	end

	// accumulate stage
	assign acc_nx = (first_s1 ? '0 : acc_q) + (sub_s1 ? -prod_s1 : prod_s1);
	assign rnd_w = round16(acc_nx);

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		sub_s1 <= op_sub;
		first_s1 <= op_first;
		dst_s1 <= op_dst;
	end

	// results of the multiply-accumulate
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_nx;
			case (dst_s1)
				D_C0: c_q[0] <= acc_nx;
				D_C1: c_q[1] <= acc_nx;
				D_C2: c_q[2] <= acc_nx;
				D_Y0: y_q[0] <= rnd_w[AW-1:0];
				D_Y1: y_q[1] <= rnd_w[AW-1:0];
				D_Y2: y_q[2] <= rnd_w[AW-1:0];
				D_T0: t_q[0] <= sat32(round16(-acc_nx));
				D_T1: t_q[1] <= sat32(round16(-acc_nx));
				D_T2: t_q[2] <= sat32(round16(-acc_nx));
				default: acc_q <= acc_nx;
			endcase
		end
	end

	// item registers and normalizer results
	always_ff @(posedge clk) begin
		if (q_pop) begin
			eye_q[0] <= q_item.eye_x;
			eye_q[1] <= q_item.eye_y;
			eye_q[2] <= q_item.eye_z;
			up_q[0] <= q_item.up_x;
			up_q[1] <= q_item.up_y;
			up_q[2] <= q_item.up_z;
		end
		if (state_q == B_NZ && ndone) begin
			z_q[0] <= nr0;
			z_q[1] <= nr1;
			z_q[2] <= nr2;
			degen_q <= nzero;
		end
		if (state_q == B_NX && ndone) begin
			x_q[0] <= nr0;
			x_q[1] <= nr1;
			x_q[2] <= nr2;
			degen_q <= degen_q | nzero;
		end
	end

	// sequencer
	assign hand = (state_q == B_HAND) && !vld_s1 && !ob_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= 4'd0;
			cstart_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			cstart_q <= vld_s1 && (dst_s1 == D_C2);
			case (state_q)
				B_IDLE: if (q_valid) state_q <= B_NZ;
				B_NZ: begin
					if (ndone) begin
						state_q <= B_C;
						step_q <= 4'd0;
					end
				end
				B_C: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd5) state_q <= B_NX;
				end
				B_NX: begin
					if (ndone) begin
						state_q <= B_YT;
						step_q <= 4'd0;
					end
				end
				B_YT: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd14) state_q <= B_HAND;
				end
				B_HAND: if (hand) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// output buffer control
	assign out_xfer = ob_busy_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_busy_q <= 1'b0;
			row_q <= 2'd0;
		end else begin
			if (hand) begin
				ob_busy_q <= 1'b1;
				row_q <= 2'd0;
			end else if (out_xfer) begin
				row_q <= row_q + 2'd1;
				if (row_q == 2'd3) ob_busy_q <= 1'b0;
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (hand) begin
			ob_x_q <= x_q;
			ob_y_q <= y_q;
			ob_z_q <= z_q;
			ob_t_q <= t_q;
			ob_degen_q <= degen_q;
		end
	end

	// row select
	always_comb begin
		case (row_q)
			2'd0: begin
				elem0 = CW'(ob_x_q[0]);
				elem1 = CW'(ob_x_q[1]);
				elem2 = CW'(ob_x_q[2]);
				elem3 = ob_t_q[0];
			end
			2'd1: begin
				elem0 = CW'(ob_y_q[0]);
				elem1 = CW'(ob_y_q[1]);
				elem2 = CW'(ob_y_q[2]);
				elem3 = ob_t_q[1];
			end
			2'd2: begin
				elem0 = CW'(ob_z_q[0]);
				elem1 = CW'(ob_z_q[1]);
				elem2 = CW'(ob_z_q[2]);
				elem3 = ob_t_q[2];
			end
			default: begin
				elem0 = '0;
				elem1 = '0;
				elem2 = '0;
				elem3 = Q_ONE;
			end
		endcase
	end

	assign out_valid = ob_busy_q;
	assign row_number = row_q;
	assign last_row = (row_q == 2'd3);
	assign degenerate = ob_degen_q;

endmodule

>>> rtl/look_at_view_matrix.sv
// look-at view matrix, signed Q16.16; four row transfers per input transfer
// per item: two normalizer runs (each 0 to 30 shift steps, a 32-step square root
// and three 17-step divides) plus 21 multiplies; an axis of zero length skips its
// shift, root and divide steps, so the pass is shorter, most of all when eye equals target
// throughput: one item per back-end pass; rows drain while the next item computes
// reset: arst_n clears the queue, sequencers and output buffer; no clearing pass
module look_at_view_matrix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] target_x,
	input  logic [31:0] target_y,
	input  logic [31:0] target_z,
	input  logic [31:0] eye_x,
	input  logic [31:0] eye_y,
	input  logic [31:0] eye_z,
	input  logic [31:0] up_x,
	input  logic [31:0] up_y,
	input  logic [31:0] up_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  row_number,
	output logic [31:0] elem0,
	output logic [31:0] elem1,
	output logic [31:0] elem2,
	output logic [31:0] elem3,
	output logic        last_row,
	output logic        degenerate
);
	import lav_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// front end with item queue
	lav_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.eye_x    (eye_x),
		.eye_y    (eye_y),
		.eye_z    (eye_z),
		.up_x     (up_x),
		.up_y     (up_y),
		.up_z     (up_z),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// back end with matrix datapath and output buffer
	lav_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_number (row_number),
		.elem0      (elem0),
		.elem1      (elem1),
		.elem2      (elem2),
		.elem3      (elem3),
		.last_row   (last_row),
		.degenerate (degenerate)
	);

endmodule
